>>> sv/hsvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvs_pkg: shared types, constants and mask helpers
// Sizes of the worker vectors, the topology bundle and the tier bundle.
// ----------------------------------------------------------------------------
package hsvs_pkg;

	localparam int MAX_WORKERS = 64;
	localparam int WORKER_W    = $clog2(MAX_WORKERS);
	localparam int REQ_W       = 6;
	localparam int CFG_W       = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int PROD_W      = WORKER_W + CFG_W;
	localparam int TOTAL_W     = 2 * CFG_W;

	typedef logic [MAX_WORKERS-1:0] wvec_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WORKERS_PER_DOMAIN  = 2'd0,
		REG_DOMAINS_PER_SUPER   = 2'd1,
		REG_SUPERDOMAIN_COUNT   = 2'd2
	} cfg_reg_t;

	// static topology derived from the config registers
	typedef struct packed {
		wvec_t             dstart; // worker opens a domain
		wvec_t             sstart; // worker opens a superdomain
		logic [CFG_W-1:0]  total;  // saturated worker total
	} topo_t;

	// candidate vectors per steal tier
	typedef struct packed {
		logic  valid;
		wvec_t own_dom;
		wvec_t own_super;
		wvec_t remote;
	} tiers_t;

	function automatic wvec_t rev_w(input wvec_t v);
		wvec_t o;
		for (int i = 0; i < MAX_WORKERS; i++) begin
			o[i] = v[MAX_WORKERS-1-i];
		end
		return o;
	endfunction

	// Workers that share r's group, given a vector of group start positions.
	// The group runs from the last start at or below r up to the next start.
	function automatic wvec_t group_mask(input wvec_t starts, input logic [REQ_W-1:0] r);
		wvec_t le;
		wvec_t x;
		wvec_t y;
		wvec_t below_hi;
		wvec_t ge_lo;
		le       = ~((~wvec_t'(0) << r) << 1);
		x        = starts & ~le;
		below_hi = ~x & (x - wvec_t'(1));
		y        = rev_w(starts & le);
		ge_lo    = rev_w(y ^ (y - wvec_t'(1)));
		return ge_lo & below_hi;
	endfunction

endpackage

>>> sv/hsvs_topo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvs_topo: topology registers
// Holds the three config registers and derives group start vectors and the
// saturated worker total in two registered levels.
// ----------------------------------------------------------------------------
module hsvs_topo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [hsvs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hsvs_pkg::CFG_W-1:0] cfg_wdata,
	output hsvs_pkg::topo_t            topo
);
	import hsvs_pkg::*;

	logic [CFG_W-1:0]  wpd_q;
	logic [CFG_W-1:0]  dps_q;
	logic [CFG_W-1:0]  sdc_q;

	// level 1
	wvec_t             dstart_q;
	logic [CFG_W-1:0]  sdsz_q;
	// level 2
	wvec_t             sstart_q;
	logic [CFG_W-1:0]  total_q;

	wvec_t             dstart_d;
	wvec_t             sstart_d;
	logic [PROD_W-1:0] dprod [MAX_WORKERS];
	logic [PROD_W-1:0] sprod [MAX_WORKERS];
	logic [TOTAL_W-1:0] sd_full;
	logic [CFG_W-1:0]  sdsz_d;
	logic [TOTAL_W-1:0] tot_full;
	logic [CFG_W-1:0]  total_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpd_q <= CFG_W'(1);
			dps_q <= CFG_W'(1);
			sdc_q <= CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WORKERS_PER_DOMAIN: wpd_q <= cfg_wdata;
				REG_DOMAINS_PER_SUPER:  dps_q <= cfg_wdata;
				REG_SUPERDOMAIN_COUNT:  sdc_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// multiples of the group size mark group starts
	always_comb begin
		dstart_d = '0;
		for (int k = 0; k < MAX_WORKERS; k++) begin
			dprod[k] = PROD_W'(k) * PROD_W'(wpd_q);
			if (dprod[k] < PROD_W'(MAX_WORKERS)) begin
				dstart_d[dprod[k][WORKER_W-1:0]] = 1'b1;
			end
		end
	end

	assign sd_full = TOTAL_W'(wpd_q) * TOTAL_W'(dps_q);
	assign sdsz_d  = (sd_full > TOTAL_W'(MAX_WORKERS)) ? CFG_W'(MAX_WORKERS)
	                                                    : sd_full[CFG_W-1:0];

	always_comb begin
		sstart_d = '0;
		for (int k = 0; k < MAX_WORKERS; k++) begin
			sprod[k] = PROD_W'(k) * PROD_W'(sdsz_q);
			if (sprod[k] < PROD_W'(MAX_WORKERS)) begin
				sstart_d[sprod[k][WORKER_W-1:0]] = 1'b1;
			end
		end
	end

	assign tot_full = TOTAL_W'(sdsz_q) * TOTAL_W'(sdc_q);
	assign total_d  = (tot_full > TOTAL_W'(MAX_WORKERS)) ? CFG_W'(MAX_WORKERS)
	                                                      : tot_full[CFG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dstart_q <= '1;
			sdsz_q   <= CFG_W'(1);
			sstart_q <= '1;
			total_q  <= CFG_W'(1);
		end else begin
			dstart_q <= dstart_d;
			sdsz_q   <= sdsz_d;
			sstart_q <= sstart_d;
			total_q  <= total_d;
		end
	end

	assign topo.dstart = dstart_q;
	assign topo.sstart = sstart_q;
	assign topo.total  = total_q;

endmodule

>>> sv/hsvs_tier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvs_tier: tier split
// Stages 1 to 3: capture the request, build the own-domain mask, then the
// superdomain mask and the three tier candidate vectors.
// ----------------------------------------------------------------------------
module hsvs_tier (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic [hsvs_pkg::REQ_W-1:0] requester,
	input  logic [63:0]                nonempty_mask,
	input  hsvs_pkg::topo_t            topo,
	output hsvs_pkg::tiers_t           tiers
);
	import hsvs_pkg::*;

	logic              v_s1, v_s2, v_s3;
	logic [REQ_W-1:0]  r_s1, r_s2;
	wvec_t             mask_s1, mask_s2;
	wvec_t             dm_s2;
	wvec_t             t0_s3, t1_s3, t2_s3;

	wvec_t             sm;
	wvec_t             in_range;
	wvec_t             cand;
	logic              r_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: capture
	always_ff @(posedge clk) begin
		if (take) begin
			r_s1    <= requester;
			mask_s1 <= nonempty_mask[MAX_WORKERS-1:0];
		end
	end

	// stage 2: own domain
	always_ff @(posedge clk) begin
		r_s2    <= r_s1;
		mask_s2 <= mask_s1;
		dm_s2   <= group_mask(topo.dstart, r_s1);
	end

	// stage 3: superdomain, range, self exclusion
	assign sm       = group_mask(topo.sstart, r_s2);
	assign in_range = ~(~wvec_t'(0) << topo.total);
	assign r_ok     = {1'b0, r_s2} < topo.total;
	assign cand     = r_ok ? (mask_s2 & in_range & ~(wvec_t'(1) << r_s2)) : '0;

	always_ff @(posedge clk) begin
		t0_s3 <= cand & dm_s2;
		t1_s3 <= cand & sm & ~dm_s2;
		t2_s3 <= cand & ~sm & ~dm_s2;
	end

	assign tiers.valid     = v_s3;
	assign tiers.own_dom   = t0_s3;
	assign tiers.own_super = t1_s3;
	assign tiers.remote    = t2_s3;

endmodule

>>> sv/hsvs_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvs_pick: victim pick
// Stage 4 isolates the lowest candidate of each tier, stage 5 takes the
// first non-empty tier and encodes the victim number.
// ----------------------------------------------------------------------------
module hsvs_pick (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hsvs_pkg::tiers_t           tiers,
	output logic                       done,
	output logic                       found,
	output logic [hsvs_pkg::REQ_W-1:0] victim
);
	import hsvs_pkg::*;

	logic              v_s4, v_s5;
	wvec_t             iso0_s4, iso1_s4, iso2_s4;
	logic              any0_s4, any1_s4, any2_s4;
	logic              found_s5;
	logic [REQ_W-1:0]  victim_s5;

	wvec_t             sel;
	logic [REQ_W-1:0]  idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= tiers.valid;
			v_s5 <= v_s4;
		end
	end

	// stage 4: lowest set bit per tier
	always_ff @(posedge clk) begin
		iso0_s4 <= tiers.own_dom   & (~tiers.own_dom   + wvec_t'(1));
		iso1_s4 <= tiers.own_super & (~tiers.own_super + wvec_t'(1));
		iso2_s4 <= tiers.remote    & (~tiers.remote    + wvec_t'(1));
		any0_s4 <= |tiers.own_dom;
		any1_s4 <= |tiers.own_super;
		any2_s4 <= |tiers.remote;
	end

	// stage 5: tier priority and encode
	assign sel = any0_s4 ? iso0_s4 : (any1_s4 ? iso1_s4 : iso2_s4);

	always_comb begin
		idx = '0;
		for (int w = 0; w < MAX_WORKERS; w++) begin
			if (sel[w]) begin
				idx = idx | REQ_W'(w);
			end
		end
	end

	always_ff @(posedge clk) begin
		found_s5  <= any0_s4 | any1_s4 | any2_s4;
		victim_s5 <= idx;
	end

	assign done   = v_s5;
	assign found  = found_s5;
	assign victim = victim_s5;

endmodule

>>> sv/hierarchical_steal_victim_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_steal_victim_select: hierarchical steal victim selector
// Picks the first worker with a non-empty queue in the requester's steal
// order: own domain, then own superdomain, then everyone else, ascending.
// ----------------------------------------------------------------------------
//  channel   | ports                              | handshake
//  ----------+------------------------------------+---------------------------
//  request   | requester, nonempty_mask           | start && !busy
//  result    | found, victim                      | done, one cycle, no stall
//  config    | cfg_index, cfg_wdata               | cfg_we
//
// One request per cycle, through capture, own-domain mask, superdomain mask
// and tier split, lowest bit per tier, tier pick and encode. Each request is
// independent, so busy stays low.
// Reset restores all three topology registers to 1 (one worker in total) and
// empties the pipeline. The result side cannot stall; done pulses once.
// A config write reaches the domain table through the first registered level
// and the superdomain table and worker total through the second level, in step
// with the stage that reads each of them.
// ----------------------------------------------------------------------------
module hierarchical_steal_victim_select (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [hsvs_pkg::REQ_W-1:0]     requester,
	input  logic [63:0]                    nonempty_mask,
	output logic                           done,
	output logic                           found,
	output logic [hsvs_pkg::REQ_W-1:0]     victim,
	input  logic                           cfg_we,
	input  logic [hsvs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hsvs_pkg::CFG_W-1:0]     cfg_wdata
);
	import hsvs_pkg::*;

	topo_t  topo;
	tiers_t tiers;
	logic   take;

	// fully pipelined: never refuses a request
	assign busy = 1'b0;
	assign take = start & ~busy;

	// topology registers and derived group tables
	hsvs_topo u_topo (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.topo      (topo)
	);

	// stages 1-3: split candidates into the three tiers
	hsvs_tier u_tier (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.requester     (requester),
		.nonempty_mask (nonempty_mask),
		.topo          (topo),
		.tiers         (tiers)
	);

	// stages 4-5: first tier with a candidate, lowest number wins
	hsvs_pick u_pick (
		.clk    (clk),
		.arst_n (arst_n),
		.tiers  (tiers),
		.done   (done),
		.found  (found),
		.victim (victim)
	);

endmodule
